### hdl/tdbc_pkg.sv
// Thermostat dead-band controller: shared types, codes and reset values.
// No dependencies; used by every other file of the block.
package tdbc_pkg;

    localparam int TEMP_W  = 12;
    localparam int COUNT_W = 16;
    localparam int BAND_W  = 11;
    localparam int MODE_W  = 2;
    localparam int REQ_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // control mode codes
    localparam logic [MODE_W-1:0] MODE_FAN     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NATURAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HEAT    = 2'd2;

    // remote UV commands
    localparam logic [REQ_W-1:0] REMOTE_NONE   = 2'd0;
    localparam logic [REQ_W-1:0] REMOTE_ON     = 2'd1;
    localparam logic [REQ_W-1:0] REMOTE_OFF    = 2'd2;
    localparam logic [REQ_W-1:0] REMOTE_TOGGLE = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DANGER_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_HIGH = 3'd5;

    // reset values
    localparam logic [COUNT_W-1:0]       RST_PERIOD_TICKS  = 16'd1000;
    localparam logic [COUNT_W-1:0]       RST_LOCKOUT_TICKS = 16'd300;
    localparam logic signed [TEMP_W-1:0] RST_DANGER_LEVEL  = 12'sd640;
    localparam logic [BAND_W-1:0]        RST_DEAD_BAND     = 11'd16;
    localparam logic signed [TEMP_W-1:0] RST_SETPOINT_LOW  = 12'sd320;
    localparam logic signed [TEMP_W-1:0] RST_SETPOINT_HIGH = 12'sd560;
    localparam logic signed [TEMP_W-1:0] RST_SETPOINT      = 12'sd400;

    localparam logic signed [TEMP_W:0]   ONE_DEGREE = 13'sd16;
    localparam logic signed [TEMP_W:0]   SP_MAX     = 13'sd2047;
    localparam logic signed [TEMP_W:0]   SP_MIN     = -13'sd2048;
    localparam logic [COUNT_W-1:0]       COUNT_MAX  = 16'hFFFF;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature_sample;
        logic                     setting_mode;
        logic                     up_pressed;
        logic                     down_pressed;
        logic                     uv_switch;
        logic [REQ_W-1:0]         remote_uv_request;
    } req_t;

    typedef struct packed {
        logic                     heater_on;
        logic                     fan_on;
        logic                     uv_on;
        logic [MODE_W-1:0]        control_mode;
        logic signed [TEMP_W-1:0] current_setpoint;
        logic signed [TEMP_W-1:0] latched_temperature;
        logic                     sample_taken;
    } result_t;

    typedef struct packed {
        logic [COUNT_W-1:0]       period_ticks;
        logic [COUNT_W-1:0]       lockout_ticks;
        logic signed [TEMP_W-1:0] danger_level;
        logic [BAND_W-1:0]        dead_band;
        logic signed [TEMP_W-1:0] setpoint_low;
        logic signed [TEMP_W-1:0] setpoint_high;
    } cfg_t;

endpackage

### hdl/tdbc_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on tdbc_pkg for the payload types.
interface tdbc_req_if;
    logic             valid;
    logic             ready;
    tdbc_pkg::req_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tdbc_result_if;
    logic              valid;
    logic              ready;
    tdbc_pkg::result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hdl/tdbc_cfg.sv
// Configuration register file, write only.
// Depends on tdbc_pkg.
module tdbc_cfg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [tdbc_pkg::CFG_IDX_W-1:0]       index,
    input  logic [tdbc_pkg::CFG_DATA_W-1:0]      data,
    output tdbc_pkg::cfg_t                       cfg
);

    tdbc_pkg::cfg_t cfg_reg;
    tdbc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (index)
                tdbc_pkg::REG_PERIOD_TICKS:  cfg_next.period_ticks  = data;
                tdbc_pkg::REG_LOCKOUT_TICKS: cfg_next.lockout_ticks = data;
                tdbc_pkg::REG_DANGER_LEVEL:
                    cfg_next.danger_level = $signed(data[tdbc_pkg::TEMP_W-1:0]);
                tdbc_pkg::REG_DEAD_BAND:
                    cfg_next.dead_band = data[tdbc_pkg::BAND_W-1:0];
                tdbc_pkg::REG_SETPOINT_LOW:
                    cfg_next.setpoint_low = $signed(data[tdbc_pkg::TEMP_W-1:0]);
                tdbc_pkg::REG_SETPOINT_HIGH:
                    cfg_next.setpoint_high = $signed(data[tdbc_pkg::TEMP_W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_ticks  <= tdbc_pkg::RST_PERIOD_TICKS;
            cfg_reg.lockout_ticks <= tdbc_pkg::RST_LOCKOUT_TICKS;
            cfg_reg.danger_level  <= tdbc_pkg::RST_DANGER_LEVEL;
            cfg_reg.dead_band     <= tdbc_pkg::RST_DEAD_BAND;
            cfg_reg.setpoint_low  <= tdbc_pkg::RST_SETPOINT_LOW;
            cfg_reg.setpoint_high <= tdbc_pkg::RST_SETPOINT_HIGH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/tdbc_ctrl.sv
// Controller state and per-tick decision logic: counters, mode, setpoint, UV.
// Depends on tdbc_pkg. State advances when step_en is high.
module tdbc_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  tdbc_pkg::req_t       req,
    input  tdbc_pkg::cfg_t       cfg,
    output tdbc_pkg::result_t    res
);

    logic [tdbc_pkg::MODE_W-1:0]         mode_reg,        mode_next;
    logic signed [tdbc_pkg::TEMP_W-1:0]  setpoint_reg,    setpoint_next;
    logic [tdbc_pkg::COUNT_W-1:0]        period_cnt_reg,  period_cnt_next;
    logic                                lockout_reg,     lockout_next;
    logic [tdbc_pkg::COUNT_W-1:0]        lockout_cnt_reg, lockout_cnt_next;
    logic                                remote_en_reg,   remote_en_next;
    logic                                remote_flag_reg, remote_flag_next;
    logic signed [tdbc_pkg::TEMP_W-1:0]  held_temp_reg,   held_temp_next;

    logic                                remote_en_mid;
    logic                                uv;
    logic                                sampled;
    logic [tdbc_pkg::COUNT_W-1:0]        period_inc;
    logic [tdbc_pkg::COUNT_W-1:0]        lockout_inc;
    logic signed [tdbc_pkg::TEMP_W+1:0]  sp_ext;
    logic signed [tdbc_pkg::TEMP_W+1:0]  t_ext;
    logic signed [tdbc_pkg::TEMP_W+1:0]  band_ext;
    logic signed [tdbc_pkg::TEMP_W+1:0]  band_hi;
    logic signed [tdbc_pkg::TEMP_W+1:0]  band_lo;
    logic signed [tdbc_pkg::TEMP_W:0]    sp_up;
    logic signed [tdbc_pkg::TEMP_W:0]    sp_dn;

    always_comb
    begin
        sp_ext   = {{2{setpoint_reg[tdbc_pkg::TEMP_W-1]}}, setpoint_reg};
        t_ext    = {{2{req.temperature_sample[tdbc_pkg::TEMP_W-1]}},
                    req.temperature_sample};
        band_ext = $signed({3'b000, cfg.dead_band});
        band_hi  = sp_ext + band_ext;
        band_lo  = sp_ext - band_ext;
        sp_up    = $signed({setpoint_reg[tdbc_pkg::TEMP_W-1], setpoint_reg})
                   + tdbc_pkg::ONE_DEGREE;
        sp_dn    = $signed({setpoint_reg[tdbc_pkg::TEMP_W-1], setpoint_reg})
                   - tdbc_pkg::ONE_DEGREE;
        period_inc  = (period_cnt_reg == tdbc_pkg::COUNT_MAX) ? period_cnt_reg
                      : period_cnt_reg + 16'd1;
        lockout_inc = (lockout_cnt_reg == tdbc_pkg::COUNT_MAX) ? lockout_cnt_reg
                      : lockout_cnt_reg + 16'd1;
    end

    always_comb
    begin
        mode_next        = mode_reg;
        setpoint_next    = setpoint_reg;
        period_cnt_next  = period_cnt_reg;
        lockout_next     = lockout_reg;
        lockout_cnt_next = lockout_reg ? lockout_inc : lockout_cnt_reg;
        remote_flag_next = remote_flag_reg;
        held_temp_next   = held_temp_reg;
        sampled          = 1'b0;

        // remote command first
        remote_en_mid = remote_en_reg;
        case (req.remote_uv_request)
            tdbc_pkg::REMOTE_ON:
            begin
                remote_en_mid    = 1'b1;
                remote_flag_next = 1'b1;
            end
            tdbc_pkg::REMOTE_OFF:
            begin
                remote_en_mid    = 1'b1;
                remote_flag_next = 1'b0;
            end
            tdbc_pkg::REMOTE_TOGGLE:
            begin
                remote_en_mid    = 1'b1;
                remote_flag_next = !remote_flag_reg;
            end
            default: ;
        endcase
        uv             = remote_en_mid ? remote_flag_next : req.uv_switch;
        remote_en_next = remote_en_mid;

        if (!req.setting_mode)
        begin
            period_cnt_next = period_inc;
            if (period_inc > cfg.period_ticks)
            begin
                period_cnt_next = '0;
                held_temp_next  = req.temperature_sample;
                sampled         = 1'b1;
                if (req.temperature_sample > cfg.danger_level)
                    mode_next = tdbc_pkg::MODE_FAN;
                else if (band_hi < t_ext)
                    mode_next = tdbc_pkg::MODE_NATURAL;
                else if (!(band_lo < t_ext))
                    mode_next = tdbc_pkg::MODE_HEAT;
            end
        end
        else
        begin
            period_cnt_next = '0;
            remote_en_next  = 1'b0;
            if (!lockout_reg)
            begin
                if (req.up_pressed)
                begin
                    lockout_next     = 1'b1;
                    lockout_cnt_next = '0;
                    if (setpoint_reg < cfg.setpoint_high)
                        setpoint_next = (sp_up > tdbc_pkg::SP_MAX)
                                        ? tdbc_pkg::SP_MAX[tdbc_pkg::TEMP_W-1:0]
                                        : sp_up[tdbc_pkg::TEMP_W-1:0];
                end
                else if (req.down_pressed)
                begin
                    lockout_next     = 1'b1;
                    lockout_cnt_next = '0;
                    if (setpoint_reg > cfg.setpoint_low)
                        setpoint_next = (sp_dn < tdbc_pkg::SP_MIN)
                                        ? tdbc_pkg::SP_MIN[tdbc_pkg::TEMP_W-1:0]
                                        : sp_dn[tdbc_pkg::TEMP_W-1:0];
                end
            end
            else if (lockout_inc > cfg.lockout_ticks)
            begin
                lockout_next     = 1'b0;
                lockout_cnt_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= tdbc_pkg::MODE_NATURAL;
            setpoint_reg    <= tdbc_pkg::RST_SETPOINT;
            period_cnt_reg  <= '0;
            lockout_reg     <= 1'b0;
            lockout_cnt_reg <= '0;
            remote_en_reg   <= 1'b0;
            remote_flag_reg <= 1'b0;
            held_temp_reg   <= '0;
        end
        else if (step_en)
        begin
            mode_reg        <= mode_next;
            setpoint_reg    <= setpoint_next;
            period_cnt_reg  <= period_cnt_next;
            lockout_reg     <= lockout_next;
            lockout_cnt_reg <= lockout_cnt_next;
            remote_en_reg   <= remote_en_next;
            remote_flag_reg <= remote_flag_next;
            held_temp_reg   <= held_temp_next;
        end
    end

    always_comb
    begin
        res.heater_on           = (mode_next != tdbc_pkg::MODE_FAN)
                                  && (mode_next != tdbc_pkg::MODE_NATURAL);
        res.fan_on              = (mode_next == tdbc_pkg::MODE_FAN);
        res.uv_on               = uv;
        res.control_mode        = mode_next;
        res.current_setpoint    = setpoint_next;
        res.latched_temperature = held_temp_next;
        res.sample_taken        = sampled;
    end

endmodule

### hdl/thermostat_dead_band_controller_core.sv
// Thermostat dead-band controller, top level: request register, controller,
// result register. Depends on tdbc_pkg, tdbc_if, tdbc_cfg and tdbc_ctrl.
//
//  channel  | role   | carries
//  ---------+--------+---------------------------------------------
//  req      | sink   | one request per tick: sample, mode, buttons
//  result   | source | heater/fan/UV drive, mode, setpoint, sample
//  cfg_*    | write  | six control registers, index 0 to 5
//
// One request per clock sustained while result.ready is high; a result is
// offered once its request has passed the request and result registers.
// The controller state moves as a request passes into the result register,
// so a stalled result holds the request stage and nothing is lost.
// Reset clears the state and loads the register defaults.
module thermostat_dead_band_controller_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    tdbc_req_if.sink                             req,
    tdbc_result_if.source                        result,
    input  logic                                 cfg_wr_en,
    input  logic [tdbc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tdbc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    tdbc_pkg::cfg_t     cfg;
    tdbc_pkg::req_t     req_data_reg;
    logic               req_valid_reg;
    tdbc_pkg::result_t  res_comb;
    tdbc_pkg::result_t  res_data_reg;
    logic               res_valid_reg;
    logic               advance;

    assign advance   = req_valid_reg && (!res_valid_reg || result.ready);
    assign req.ready = !req_valid_reg || advance;

    tdbc_cfg u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg_wr_en),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    tdbc_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .req     (req_data_reg),
        .cfg     (cfg),
        .res     (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                req_valid_reg <= req.valid;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
            req_data_reg <= req.payload;
        if (advance)
            res_data_reg <= res_comb;
    end

    assign result.valid   = res_valid_reg;
    assign result.payload = res_data_reg;

endmodule
